// ===== design/point_set_hit_test_macros.svh =====
// Assertion helpers for the point store.
`ifndef POINT_SET_HIT_TEST_MACROS_SVH
`define POINT_SET_HIT_TEST_MACROS_SVH

// Checked only outside reset.
`define PSHT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define PSHT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== design/psht_pkg.sv =====
package psht_pkg;

  localparam int unsigned PSHT_MAX_POINTS = 1024;
  localparam int unsigned COORD_W = 16;
  localparam int unsigned WIDTH_W = 8;
  localparam int unsigned OUT_CNT_W = 11;
  localparam int unsigned IN_DATA_W = 64;
  localparam int unsigned OUT_DATA_W = 16;
  localparam logic [WIDTH_W-1:0] WIDTH_RESET = 8'd1;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_NEAR   = 2'd2,
    OP_BOX    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_RESP
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;     // request accepted this cycle
    logic scan_rd;  // read next stored point
    logic post;     // move result into output register
  } psht_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_test;    // incoming request is a hit or box test
    logic empty;      // no stored points
    logic scan_last;  // current read is the last stored point
    logic out_free;   // output register can take a result
  } psht_sts_t;

endpackage

// ===== design/psht_ram.sv =====
module psht_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/psht_ctrl.sv =====
module psht_ctrl
  import psht_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  psht_sts_t sts_i,
  output psht_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (sts_i.is_test && !sts_i.empty) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_RESP;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last read data is compared this cycle
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.post = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/psht_dp.sv =====
module psht_dp
  import psht_pkg::*;
#(
  parameter int unsigned MAX_POINTS = PSHT_MAX_POINTS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [WIDTH_W-1:0]    cfg_data_i,
  input  logic [1:0]            in_op_i,
  input  logic [IN_DATA_W-1:0]  in_data_i,
  input  psht_cmd_t             cmd_i,
  output psht_sts_t             sts_o,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [OUT_DATA_W-1:0] out_data_o
);

  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam int unsigned BW = COORD_W + 1;  // bound width, room for +-reach

  op_e op_in;
  assign op_in = op_e'(in_op_i);

  logic [WIDTH_W-1:0] width_q;
  logic [CW-1:0]      count_q, count_d;
  logic [AW-1:0]      addr_q;
  logic               rd_valid_q;
  logic               hit_q, drop_q;
  logic               out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  logic signed [BW-1:0] lox_q, hix_q, loy_q, hiy_q;
  logic signed [BW-1:0] lox_d, hix_d, loy_d, hiy_d;

  logic full, we;
  logic [COORD_W-1:0] rd_x, rd_y;

  // input coordinates, sign extended by one bit
  logic signed [BW-1:0] xa, ya, xb, yb, reach;
  assign xa = $signed({in_data_i[15], in_data_i[15:0]});
  assign ya = $signed({in_data_i[31], in_data_i[31:16]});
  assign xb = $signed({in_data_i[47], in_data_i[47:32]});
  assign yb = $signed({in_data_i[63], in_data_i[63:48]});
  // width 0 gives reach -1: empty window, never hits
  assign reach = $signed({{(BW-WIDTH_W){1'b0}}, width_q}) - BW'(1);

  always_comb begin
    if (op_in == OP_NEAR) begin
      lox_d = xa - reach;
      hix_d = xa + reach;
      loy_d = ya - reach;
      hiy_d = ya + reach;
    end else begin
      lox_d = (xa < xb) ? xa : xb;
      hix_d = (xa < xb) ? xb : xa;
      loy_d = (ya < yb) ? ya : yb;
      hiy_d = (ya < yb) ? yb : ya;
    end
  end

  assign full = (count_q == CW'(MAX_POINTS));
  assign we   = cmd_i.load && (op_in == OP_APPEND) && !full;

  always_comb begin
    count_d = count_q;
    if (cmd_i.load) begin
      if (op_in == OP_CLEAR) begin
        count_d = '0;
      end else if (we) begin
        count_d = count_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= WIDTH_RESET;
      count_q     <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        width_q <= cfg_data_i;
      end
      count_q    <= count_d;
      rd_valid_q <= cmd_i.scan_rd;
      if (cmd_i.post) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // window test on the registered read data
  logic signed [BW-1:0] px, py;
  logic in_win;
  assign px = $signed({rd_x[COORD_W-1], rd_x});
  assign py = $signed({rd_y[COORD_W-1], rd_y});
  assign in_win = (px >= lox_q) && (px <= hix_q) && (py >= loy_q) && (py <= hiy_q);

  logic [CW+OUT_CNT_W-1:0] cnt_ext;
  assign cnt_ext = (CW + OUT_CNT_W)'(count_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      lox_q  <= lox_d;
      hix_q  <= hix_d;
      loy_q  <= loy_d;
      hiy_q  <= hiy_d;
      addr_q <= '0;
      hit_q  <= 1'b0;
      drop_q <= (op_in == OP_APPEND) && full;
    end else begin
      if (cmd_i.scan_rd) begin
        addr_q <= addr_q + AW'(1);
      end
      if (rd_valid_q && in_win) begin
        hit_q <= 1'b1;
      end
    end
    if (cmd_i.post) begin
      out_data_q <= {3'b000, drop_q, cnt_ext[OUT_CNT_W-1:0], hit_q};
    end
  end

  psht_ram #(.WIDTH(COORD_W), .DEPTH(MAX_POINTS)) u_ram_x (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (in_data_i[15:0]),
    .re_i    (cmd_i.scan_rd),
    .raddr_i (addr_q),
    .rdata_o (rd_x)
  );

  psht_ram #(.WIDTH(COORD_W), .DEPTH(MAX_POINTS)) u_ram_y (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (in_data_i[31:16]),
    .re_i    (cmd_i.scan_rd),
    .raddr_i (addr_q),
    .rdata_o (rd_y)
  );

  assign sts_o.is_test   = (op_in == OP_NEAR) || (op_in == OP_BOX);
  assign sts_o.empty     = (count_q == '0);
  assign sts_o.scan_last = ((CW'(addr_q) + CW'(1)) == count_q);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== design/point_set_hit_test.sv =====
// Point store with hit queries. Each request on the slave stream carries an
// operation in tuser (append, clear, point hit test, rectangle test) and two
// signed 16-bit points in tdata; each request gives exactly one response on the
// master stream with the hit flag, the number of stored points after the
// request and a dropped flag (append into a full store). A test reads the
// stored points one per cycle through the single read port of the point
// memories; the next request is accepted only once the response is posted.
// The point hit test matches a stored point within stroke_width - 1 of the
// query in both x and y; width 0 never matches. The rectangle test takes the
// corners in either order, edges inclusive. A new request is taken while the
// previous response still waits on the master side. The stroke width is
// written through the cfg channel, which is always ready; write it only while
// no request is in flight. Memory contents need no clearing after reset.
module point_set_hit_test
  import psht_pkg::*;
#(
  parameter int unsigned MAX_POINTS = PSHT_MAX_POINTS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // stroke width write
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [WIDTH_W-1:0]    cfg_data_i,
  // requests
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // x_a[15:0], y_a[31:16], x_b[47:32], y_b[63:48]
  input  logic [1:0]            s_axis_tuser,  // operation[1:0]
  // responses
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata   // hit[0], stored_count[11:1], dropped[12], zero
);

  psht_cmd_t cmd;
  psht_sts_t sts;

  // config register lives in the datapath, no backpressure
  assign cfg_ready_o = 1'b1;

  psht_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  psht_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .in_op_i     (s_axis_tuser),
    .in_data_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata)
  );

endmodule

// ===== design/point_set_hit_test_checker.sv =====
`include "point_set_hit_test_macros.svh"

module point_set_hit_test_checker
  import psht_pkg::*;
#(
  parameter int unsigned MAX_POINTS = PSHT_MAX_POINTS
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  localparam logic [OUT_CNT_W-1:0] FullCnt = OUT_CNT_W'(MAX_POINTS);

  // a request is still in work in the cycle after accept
  `PSHT_ASSERT(a_busy_after_accept, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "request accepted in back-to-back cycles")

  // a drop only happens with the store full
  `PSHT_ASSERT(a_drop_full, m_axis_tvalid && m_axis_tdata[12] |-> m_axis_tdata[11:1] == FullCnt, "dropped with store not full")

  // append never hits, tests never drop
  `PSHT_ASSERT(a_hit_drop_excl, m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[12]), "hit and dropped both set")

  // response held while stalled
  `PSHT_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "response changed while stalled")

  // output held cleared while in reset
  `PSHT_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |=> !m_axis_tvalid, "response valid during reset")

endmodule

bind point_set_hit_test point_set_hit_test_checker #(.MAX_POINTS(MAX_POINTS)) u_checker (.*);

// ===== verif/point_set_hit_test_test.sv =====
`timescale 1ns / 1ps

// Stimulus and checking for the point store with hit queries.
// Requests go in on the slave stream, responses are checked in order against
// a predictor that keeps its own copy of the points and the stroke width.
module point_set_hit_test_test;
  import psht_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 400;     // long receiver hold-off
  localparam int PHASE_ITEMS = 116;     // random requests per width setting
  localparam int STORE_CAP   = 48;      // random part clears at this count
  localparam logic signed [COORD_W-1:0] CMIN = 16'sh8000;
  localparam logic signed [COORD_W-1:0] CMAX = 16'sh7fff;
  localparam logic signed [COORD_W-1:0] C0   = 16'sd0;

  // one response, as unpacked from m_axis_tdata
  typedef struct packed {
    logic                 hit;
    logic [OUT_CNT_W-1:0] count;
    logic                 dropped;
  } hit_reply_t;

  // one row of the directed script
  typedef struct packed {
    bit                         set_width;  // drain and write width first
    logic [WIDTH_W-1:0]         width;
    op_e                        op;
    logic signed [COORD_W-1:0]  xa;
    logic signed [COORD_W-1:0]  ya;
    logic signed [COORD_W-1:0]  xb;
    logic signed [COORD_W-1:0]  yb;
    bit                         typed;      // reply below is fixed, not predicted
    hit_reply_t                 reply;
  } script_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [WIDTH_W-1:0]    cfg_data = '0;
  logic                  req_valid = 1'b0;
  logic                  req_ready;
  logic [IN_DATA_W-1:0]  req_data = '0;   // x_a, y_a, x_b, y_b from bit 0 up
  logic [1:0]            req_op = '0;     // operation
  logic                  rsp_valid;
  logic                  rsp_ready = 1'b0;
  logic [OUT_DATA_W-1:0] rsp_data;        // hit, stored_count, dropped from bit 0 up

  // predictor state
  logic signed [COORD_W-1:0] pt_x [PSHT_MAX_POINTS];
  logic signed [COORD_W-1:0] pt_y [PSHT_MAX_POINTS];
  int unsigned               pt_count = 0;
  logic [WIDTH_W-1:0]        pt_width = WIDTH_RESET;

  hit_reply_t replies_due [$];
  int         mismatches = 0;
  int         replies_seen = 0;
  int         cycles = 0;

  // traffic shaping
  bit  calm = 1'b0;          // no random idling on either side
  int  stall_ask = 0;        // bumped to ask the receiver for a long hold-off
  int  stall_seen = 0;
  int  hold_left = 0;
  logic signed [COORD_W-1:0] cx = C0, cy = C0;   // random cluster center

  script_row_t script [24];

  always #5 clk_i = ~clk_i;

  point_set_hit_test dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (req_valid),
    .s_axis_tready (req_ready),
    .s_axis_tdata  (req_data),
    .s_axis_tuser  (req_op),
    .m_axis_tvalid (rsp_valid),
    .m_axis_tready (rsp_ready),
    .m_axis_tdata  (rsp_data)
  );

  // Predictor: applies one request to the local point store and returns the
  // response it must produce. Differences are taken in 32 bits, so extremes
  // of the 16-bit range never wrap.
  function automatic hit_reply_t compute_reply(op_e op,
                                               logic signed [COORD_W-1:0] xa,
                                               logic signed [COORD_W-1:0] ya,
                                               logic signed [COORD_W-1:0] xb,
                                               logic signed [COORD_W-1:0] yb);
    hit_reply_t r;
    int reach, dx, dy, xlo, xhi, ylo, yhi, px, py;
    r = '0;
    case (op)
      OP_APPEND: begin
        if (pt_count < PSHT_MAX_POINTS) begin
          pt_x[pt_count] = xa;
          pt_y[pt_count] = ya;
          pt_count++;
        end else begin
          r.dropped = 1'b1;
        end
      end
      OP_CLEAR: pt_count = 0;
      OP_NEAR: begin
        // width 0 has no neighborhood at all
        if (pt_width != '0) begin
          reach = int'(pt_width) - 1;
          for (int i = 0; i < pt_count; i++) begin
            dx = int'(pt_x[i]) - int'(xa);
            dy = int'(pt_y[i]) - int'(ya);
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            if (dx <= reach && dy <= reach) r.hit = 1'b1;
          end
        end
      end
      default: begin
        // corners in either order, edges inclusive
        xlo = (xa < xb) ? int'(xa) : int'(xb);
        xhi = (xa < xb) ? int'(xb) : int'(xa);
        ylo = (ya < yb) ? int'(ya) : int'(yb);
        yhi = (ya < yb) ? int'(yb) : int'(ya);
        for (int i = 0; i < pt_count; i++) begin
          px = int'(pt_x[i]);
          py = int'(pt_y[i]);
          if (px >= xlo && px <= xhi && py >= ylo && py <= yhi) r.hit = 1'b1;
        end
      end
    endcase
    r.count = pt_count[OUT_CNT_W-1:0];
    return r;
  endfunction

  function automatic script_row_t scripted(bit wr, logic [WIDTH_W-1:0] w, op_e op,
                                           logic signed [COORD_W-1:0] xa,
                                           logic signed [COORD_W-1:0] ya,
                                           logic signed [COORD_W-1:0] xb,
                                           logic signed [COORD_W-1:0] yb,
                                           bit typed, logic hit,
                                           logic [OUT_CNT_W-1:0] cnt, logic drop);
    script_row_t s;
    s.set_width = wr;
    s.width = w;
    s.op = op;
    s.xa = xa;
    s.ya = ya;
    s.xb = xb;
    s.yb = yb;
    s.typed = typed;
    s.reply.hit = hit;
    s.reply.count = cnt;
    s.reply.dropped = drop;
    return s;
  endfunction

  function automatic void flag(string field, logic [OUT_CNT_W-1:0] want,
                               logic [OUT_CNT_W-1:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("response %0d: %s expected %0d got %0d", replies_seen, field, want, got);
  endfunction

  // oldest expectation against the response taken at this edge
  task automatic check_reply(logic [OUT_DATA_W-1:0] d);
    hit_reply_t want;
    if (replies_due.size() == 0) begin
      flag("unexpected response, stored_count", '0, d[11:1]);
    end else begin
      want = replies_due.pop_front();
      if (d[0] !== want.hit) flag("hit", OUT_CNT_W'(want.hit), OUT_CNT_W'(d[0]));
      if (d[11:1] !== want.count) flag("stored_count", want.count, d[11:1]);
      if (d[12] !== want.dropped) flag("dropped", OUT_CNT_W'(want.dropped), OUT_CNT_W'(d[12]));
    end
    replies_seen++;
  endtask

  // Receiver: checks every accepted response, idles at random, and on request
  // holds tready low for a long stretch so the block backs up into its input.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_valid && rsp_ready) check_reply(rsp_data);
    if (stall_ask != stall_seen) begin
      stall_seen <= stall_ask;
      hold_left <= HOLD_CYCLES;
      rsp_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= calm || ($urandom_range(0, 99) >= 31);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Queue the expected response, then offer the request after a random gap
  // and hold it until accepted. tvalid is left high on return; the next call
  // or settle() takes it from there.
  task automatic send_request(op_e op, logic signed [COORD_W-1:0] xa,
                              logic signed [COORD_W-1:0] ya,
                              logic signed [COORD_W-1:0] xb,
                              logic signed [COORD_W-1:0] yb,
                              hit_reply_t fixed, bit use_fixed);
    hit_reply_t pred;
    pred = compute_reply(op, xa, ya, xb, yb);
    replies_due.insert(replies_due.size(), use_fixed ? fixed : pred);
    while (!calm && $urandom_range(0, 99) < 31) begin
      req_valid <= 1'b0;
      @(posedge clk_i);
    end
    req_valid <= 1'b1;
    req_data <= {yb, xb, ya, xa};
    req_op <= op;
    do @(posedge clk_i); while (!req_ready);
  endtask

  // Sender pause until every response is back and the block has returned to
  // idle.
  task automatic settle();
    req_valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_width(logic [WIDTH_W-1:0] w);
    settle();
    cfg_valid <= 1'b1;
    cfg_data <= w;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    pt_width = w;
  endtask

  function automatic logic signed [COORD_W-1:0] near_coord(logic signed [COORD_W-1:0] c);
    if ($urandom_range(0, 99) < 15) return COORD_W'($urandom);
    return c + COORD_W'($urandom_range(0, 48)) - 16'sd24;
  endfunction

  // Mostly requests around a cluster center so tests actually hit; the store
  // is cleared once it reaches STORE_CAP to keep scans short.
  task automatic random_request();
    int unsigned r;
    op_e op;
    logic signed [COORD_W-1:0] xa, ya, xb, yb;
    if ($urandom_range(0, 99) < 4) begin
      cx = ($urandom_range(0, 3) == 0) ? (($urandom_range(0, 1) != 0) ? CMAX : CMIN)
                                       : COORD_W'($urandom);
      cy = ($urandom_range(0, 3) == 0) ? (($urandom_range(0, 1) != 0) ? CMAX : CMIN)
                                       : COORD_W'($urandom);
    end
    r = $urandom_range(0, 99);
    if (pt_count >= STORE_CAP || r < 6) op = OP_CLEAR;
    else if (r < 45) op = OP_APPEND;
    else if (r < 72) op = OP_NEAR;
    else op = OP_BOX;
    xa = near_coord(cx);
    ya = near_coord(cy);
    // second corner is don't-care outside the box test; keep it toggling
    xb = (op == OP_BOX) ? near_coord(cx) : COORD_W'($urandom);
    yb = (op == OP_BOX) ? near_coord(cy) : COORD_W'($urandom);
    send_request(op, xa, ya, xb, yb, '0, 1'b0);
  endtask

  initial begin
    logic [WIDTH_W-1:0] phase_width [5];
    int k;
    logic signed [COORD_W-1:0] qx, qy;

    // Directed: empty store, coordinate extremes, corner order, degenerate
    // box, clear, width 0/1/2/255. Typed replies where obvious by inspection.
    script = '{
      scripted(0, 8'd0, OP_NEAR, C0, C0, C0, C0, 1, 1'b0, 11'd0, 1'b0),
      scripted(0, 8'd0, OP_BOX, CMIN, CMIN, CMAX, CMAX, 1, 1'b0, 11'd0, 1'b0),
      scripted(0, 8'd0, OP_APPEND, CMIN, CMIN, CMAX, CMAX, 1, 1'b0, 11'd1, 1'b0),
      scripted(0, 8'd0, OP_APPEND, CMAX, CMAX, CMIN, CMIN, 1, 1'b0, 11'd2, 1'b0),
      scripted(0, 8'd0, OP_NEAR, CMIN, CMIN, C0, C0, 1, 1'b1, 11'd2, 1'b0),
      scripted(0, 8'd0, OP_NEAR, 16'sh8001, CMIN, C0, C0, 1, 1'b0, 11'd2, 1'b0),
      scripted(0, 8'd0, OP_BOX, CMAX, CMAX, CMIN, CMIN, 1, 1'b1, 11'd2, 1'b0),
      scripted(0, 8'd0, OP_BOX, CMAX, CMIN, CMAX, CMIN, 1, 1'b0, 11'd2, 1'b0),
      scripted(0, 8'd0, OP_APPEND, 16'sd100, -16'sd200, C0, C0, 1, 1'b0, 11'd3, 1'b0),
      scripted(0, 8'd0, OP_BOX, 16'sd100, -16'sd200, 16'sd100, -16'sd200,
               1, 1'b1, 11'd3, 1'b0),
      scripted(0, 8'd0, OP_BOX, 16'sd200, -16'sd201, 16'sd101, -16'sd300,
               0, 1'b0, 11'd0, 1'b0),
      scripted(0, 8'd0, OP_CLEAR, CMAX, CMIN, CMAX, CMIN, 1, 1'b0, 11'd0, 1'b0),
      scripted(0, 8'd0, OP_BOX, CMIN, CMIN, CMAX, CMAX, 1, 1'b0, 11'd0, 1'b0),
      scripted(0, 8'd0, OP_APPEND, C0, C0, C0, C0, 0, 1'b0, 11'd0, 1'b0),
      scripted(0, 8'd0, OP_APPEND, 16'sd5, -16'sd5, C0, C0, 0, 1'b0, 11'd0, 1'b0),
      scripted(0, 8'd0, OP_NEAR, 16'sd1, 16'sd1, C0, C0, 0, 1'b0, 11'd0, 1'b0),
      // width zero never hits, even on an exact match
      scripted(1, 8'd0, OP_NEAR, C0, C0, C0, C0, 1, 1'b0, 11'd2, 1'b0),
      scripted(1, 8'd255, OP_NEAR, 16'sd254, -16'sd254, C0, C0, 1, 1'b1, 11'd2, 1'b0),
      scripted(0, 8'd0, OP_NEAR, 16'sd260, C0, C0, C0, 0, 1'b0, 11'd0, 1'b0),
      scripted(1, 8'd2, OP_NEAR, 16'sd6, -16'sd4, C0, C0, 0, 1'b0, 11'd0, 1'b0),
      scripted(0, 8'd0, OP_NEAR, 16'sd7, -16'sd5, C0, C0, 0, 1'b0, 11'd0, 1'b0),
      scripted(0, 8'd0, OP_APPEND, CMIN, CMAX, C0, C0, 0, 1'b0, 11'd0, 1'b0),
      scripted(1, 8'd255, OP_NEAR, CMAX, CMIN, C0, C0, 0, 1'b0, 11'd0, 1'b0),
      scripted(0, 8'd0, OP_CLEAR, C0, C0, C0, C0, 1, 1'b0, 11'd0, 1'b0)
    };

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i]) begin
      if (script[i].set_width) write_width(script[i].width);
      send_request(script[i].op, script[i].xa, script[i].ya, script[i].xb, script[i].yb,
                   script[i].reply, script[i].typed);
    end

    // Random part, one width setting per phase, extremes included.
    phase_width = '{8'd0, 8'd255, 8'd1, WIDTH_W'($urandom_range(2, 40)),
                    WIDTH_W'($urandom_range(2, 254))};
    for (int ph = 0; ph < 5; ph++) begin
      write_width(phase_width[ph]);
      // long receiver hold-off while requests keep coming
      if (ph == 2) stall_ask++;
      for (int n = 0; n < PHASE_ITEMS; n++) random_request();
    end

    // Fill the store to the top with idling off, overflow it, then scan the
    // full store a few times.
    write_width(8'd3);
    calm = 1'b1;
    send_request(OP_CLEAR, C0, C0, C0, C0, '0, 1'b0);
    for (int n = 0; n < PSHT_MAX_POINTS + 6; n++)
      send_request(OP_APPEND, COORD_W'($urandom), COORD_W'($urandom),
                   COORD_W'($urandom), COORD_W'($urandom), '0, 1'b0);
    calm = 1'b0;
    for (int n = 0; n < 4; n++) begin
      k = $urandom_range(0, PSHT_MAX_POINTS - 1);
      qx = pt_x[k];
      qy = pt_y[k];
      send_request(OP_NEAR, qx + 16'sd1, qy - 16'sd2, C0, C0, '0, 1'b0);
      send_request(OP_BOX, qx - 16'sd3, qy + 16'sd1, qx + 16'sd2, qy - 16'sd4, '0, 1'b0);
      send_request(OP_NEAR, COORD_W'($urandom), COORD_W'($urandom), C0, C0, '0, 1'b0);
    end
    send_request(OP_BOX, CMAX, CMIN, CMIN, CMAX, '0, 1'b0);
    write_width(8'd0);
    send_request(OP_NEAR, qx, qy, C0, C0, '0, 1'b0);
    send_request(OP_CLEAR, C0, C0, C0, C0, '0, 1'b0);

    settle();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
